FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, muted while reset is low.
`define ASSERT_RST(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Concurrent check sampled on the rising clock, live during reset too.
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: design/lpl_pkg.sv
package lpl_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int GAIN_BITS     = 17;
  localparam int FRAC_BITS     = 16;
  localparam int CEIL_BITS     = 24;
  localparam int COEFF_BITS    = 16;
  localparam int LOOK_BITS     = 10;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int MAX_DELAY_DEF = 1024;

  localparam logic [GAIN_BITS-1:0]  UNITY_GAIN  = 17'h10000;
  localparam logic [CEIL_BITS-1:0]  CEIL_RESET  = 24'h800000;
  localparam logic [COEFF_BITS-1:0] COEFF_RESET = 16'd65509;
  localparam logic [LOOK_BITS-1:0]  LOOK_RESET  = 10'd240;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CEILING   = 2'd0,
    REG_RELEASE   = 2'd1,
    REG_LOOKAHEAD = 2'd2
  } cfg_reg_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample_left;
    sample_t sample_right;
  } in_item_t;

  typedef struct packed {
    sample_t                out_left;
    sample_t                out_right;
    logic [GAIN_BITS-1:0]   gain_now;
  } out_item_t;

endpackage

FILE: design/lookahead_peak_limiter.sv
// Stereo look-ahead peak limiter with instant attack and one-pole release.
// Each request carries one frame; the result is the frame delayed by
// lookahead_samples (saturated to MAX_DELAY-1) and scaled by the held gain,
// plus that gain in Q1.16. An accepted frame passes through the divide, the
// release steps, the two channel products and a final step that offers its
// result; no new frame is taken until then, and the last step also waits
// while the previous result is still held by a stall. The work is done by the
// bit-serial divider that forms ceiling/peak followed by the
// single shared multiplier, used four times for the release filter and the
// two channel products. After reset the block runs a clearing pass over
// every entry of the delay memory and takes no frame until it ends;
// configuration writes are taken at any time and must only be issued
// while the block is idle.
module lookahead_peak_limiter #(
  parameter int MAX_DELAY = lpl_pkg::MAX_DELAY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lpl_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lpl_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lpl_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lpl_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import lpl_pkg::*;

  `include "assert_macros.svh"

  localparam int AW       = $clog2(MAX_DELAY);
  localparam int MemBits  = 2 * SAMPLE_BITS;
  localparam int OpaBits  = SAMPLE_BITS + 1;
  localparam int OpbBits  = GAIN_BITS + 1;
  localparam int ProdBits = OpaBits + OpbBits;
  localparam int AccBits  = 2 * GAIN_BITS + 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_REL_A, ST_REL_B, ST_REL_C,
    ST_OUT_L, ST_OUT_R, ST_FIN
  } state_e;

  state_e state_q;

  logic [CEIL_BITS-1:0]  ceiling_q;
  logic [COEFF_BITS-1:0] coeff_q;
  logic [LOOK_BITS-1:0]  look_q;

  logic [AW-1:0]         wp_q;
  logic [AW-1:0]         clr_q;
  logic [AW-1:0]         rd_addr_q;
  logic [AW-1:0]         rd_addr_d;
  logic [AW-1:0]         dsat;
  logic [MemBits-1:0]    mem [MAX_DELAY];
  logic [MemBits-1:0]    rd_data_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MemBits-1:0]    mem_wdata;

  logic [GAIN_BITS-1:0]  gain_q;
  logic [GAIN_BITS-1:0]  gain_d;
  logic [GAIN_BITS-1:0]  target_q;
  logic                  over_q;
  logic [SAMPLE_BITS-1:0] mag_l;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SAMPLE_BITS-1:0] peak;

  logic                  accept;
  logic                  div_done;
  logic [FRAC_BITS-1:0]  quot;

  logic signed [OpaBits-1:0]  mul_a;
  logic signed [OpbBits-1:0]  mul_b;
  logic signed [ProdBits-1:0] prod_q;
  logic [AccBits-1:0]         acc_q;
  logic [AccBits-1:0]         sum;
  sample_t                    res_l_q;
  logic                       out_valid_q;
  out_item_t                  out_data_q;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // peak of the incoming frame
  assign mag_l = in_data_i.sample_left[SAMPLE_BITS-1]
               ? (~in_data_i.sample_left) + 1'b1 : in_data_i.sample_left;
  assign mag_r = in_data_i.sample_right[SAMPLE_BITS-1]
               ? (~in_data_i.sample_right) + 1'b1 : in_data_i.sample_right;
  assign peak  = (mag_l > mag_r) ? mag_l : mag_r;

  // read address: write position minus saturated delay, modulo depth
  always_comb begin
    if (32'(look_q) >= MAX_DELAY) begin
      dsat = AW'(MAX_DELAY - 1);
    end else begin
      dsat = AW'(look_q);
    end
    if (wp_q >= dsat) begin
      rd_addr_d = wp_q - dsat;
    end else begin
      rd_addr_d = AW'(32'(wp_q) + MAX_DELAY - 32'(dsat));
    end
  end

  lpl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (ceiling_q),
    .divisor_i  (peak),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_REL_A: begin
        mul_a = OpaBits'({1'b0, coeff_q});
        mul_b = {1'b0, gain_q};
      end
      ST_REL_B: begin
        mul_a = OpaBits'(UNITY_GAIN - {1'b0, coeff_q});
        mul_b = {1'b0, target_q};
      end
      ST_OUT_L: begin
        mul_a = OpaBits'($signed(rd_data_q[MemBits-1:SAMPLE_BITS]));
        mul_b = {1'b0, gain_q};
      end
      ST_OUT_R: begin
        mul_a = OpaBits'($signed(rd_data_q[SAMPLE_BITS-1:0]));
        mul_b = {1'b0, gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum    = acc_q + prod_q[AccBits-1:0];
  assign gain_d = (target_q < gain_q) ? target_q
                                      : sum[FRAC_BITS+GAIN_BITS-1:FRAC_BITS];

  assign mem_we    = (state_q == ST_CLEAR) || accept;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0
                   : {in_data_i.sample_left, in_data_i.sample_right};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= CEIL_RESET;
      coeff_q   <= COEFF_RESET;
      look_q    <= LOOK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CEILING:   ceiling_q <= cfg_data_i;
        REG_RELEASE:   coeff_q   <= cfg_data_i[COEFF_BITS-1:0];
        REG_LOOKAHEAD: look_q    <= cfg_data_i[LOOK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      gain_q      <= UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      // the final step updates the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == MAX_DELAY - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_addr_q <= rd_addr_d;
            over_q    <= peak > ceiling_q;
            wp_q      <= (32'(wp_q) == MAX_DELAY - 1) ? '0 : wp_q + 1'b1;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            target_q <= over_q ? {1'b0, quot} : UNITY_GAIN;
            state_q  <= ST_REL_A;
          end
        end
        ST_REL_A: begin
          prod_q  <= mul_a * mul_b;
          state_q <= ST_REL_B;
        end
        ST_REL_B: begin
          acc_q   <= prod_q[AccBits-1:0];
          prod_q  <= mul_a * mul_b;
          state_q <= ST_REL_C;
        end
        ST_REL_C: begin
          gain_q  <= gain_d;
          state_q <= ST_OUT_L;
        end
        ST_OUT_L: begin
          prod_q  <= mul_a * mul_b;
          state_q <= ST_OUT_R;
        end
        ST_OUT_R: begin
          // arithmetic shift by the gain fraction floors toward minus infinity
          res_l_q <= prod_q[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
          prod_q  <= mul_a * mul_b;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q           <= 1'b1;
            out_data_q.out_left   <= res_l_q;
            out_data_q.out_right  <= prod_q[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
            out_data_q.gain_now   <= gain_q;
            state_q               <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, accept |=> in_stall_o)
  `ASSERT_RST(a_result_from_fin, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == ST_FIN))
  `ASSERT_RST(a_gain_bounded, clk_i, rst_ni, gain_q <= UNITY_GAIN)

endmodule

FILE: design/lpl_div.sv
module lpl_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lpl_pkg::CEIL_BITS-1:0]  dividend_i,
  input  logic [lpl_pkg::SAMPLE_BITS-1:0] divisor_i,
  output logic                           done_o,
  output logic [lpl_pkg::FRAC_BITS-1:0]  quot_o
);
  import lpl_pkg::*;

  localparam int CntBits = $clog2(FRAC_BITS + 1);
  localparam int RemBits = CEIL_BITS + 1;

  logic                   busy_q;
  logic [CntBits-1:0]     cnt_q;
  logic [RemBits-1:0]     rem_q;
  logic [SAMPLE_BITS-1:0] div_q;
  logic [FRAC_BITS-1:0]   quot_q;

  logic [RemBits:0]       trial;
  logic [RemBits:0]       diff;
  logic                   fits;

  // restoring division, one quotient bit per cycle; the remainder starts
  // as the ceiling, valid whenever ceiling < peak
  assign trial = {rem_q, 1'b0};
  assign diff  = trial - {{(RemBits + 1 - SAMPLE_BITS){1'b0}}, div_q};
  assign fits  = trial >= {{(RemBits + 1 - SAMPLE_BITS){1'b0}}, div_q};

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(FRAC_BITS);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q  <= fits ? diff[RemBits-1:0] : trial[RemBits-1:0];
      quot_q <= {quot_q[FRAC_BITS-2:0], fits};
    end
  end

endmodule
